// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the stepper phase sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define SPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define SPS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/sps_pkg.sv -----
// Package with types, codes and phase tables of the stepper phase sequencer.
package sps_pkg;

    localparam int TPS_W   = 27;
    localparam int SPEED_W = 31;
    localparam int POS_W   = 32;
    localparam int RATE_W  = 32;
    localparam int VAL_W   = 32;
    localparam int BITCNT_W = $clog2(TPS_W);

    // Command codes.
    typedef enum logic [1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_POWER_ON  = 2'd1,
        FUNC_POWER_OFF = 2'd2,
        FUNC_MOVE      = 2'd3
    } func_t;

    // Move modes; the two upper codes are unsupported.
    localparam logic [1:0] MODE_POSITION = 2'd0;
    localparam logic [1:0] MODE_VELOCITY = 2'd1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_POWERED_OFF = 2'd1;
    localparam logic [1:0] STATUS_BAD_MODE    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TICKS_PER_SECOND   = 2'd0;
    localparam logic [1:0] REG_INITIAL_SPEED      = 2'd1;
    localparam logic [1:0] REG_INITIAL_RESOLUTION = 2'd2;

    // Reset values.
    localparam logic [TPS_W-1:0]   TPS_RESET   = 27'd1000000;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 31'd200;
    localparam logic               HALF_RESET  = 1'b1;

    localparam logic [SPEED_W-1:0] MAG_MAX = {SPEED_W{1'b1}};

    // Pin levels a,c,b,d in bits 3..0.
    localparam logic [3:0] FULL_TABLE [4] = '{4'hC, 4'h6, 4'h3, 4'h9};
    localparam logic [3:0] HALF_TABLE [8] =
        '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

    // Pick the coil pattern from the low position bits.
    function automatic logic [3:0] phase_lookup(input logic half, input logic [2:0] pos);
        logic [3:0] pat;
        if (half)
            pat = HALF_TABLE[pos];
        else
            pat = FULL_TABLE[pos[1:0]];
        return pat;
    endfunction

endpackage

// ----- rtl/sps_ifs.sv -----
// Handshake interfaces for the command, result and configuration channels.
interface sps_cmd_if;
    import sps_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [1:0]               move_mode;
    logic signed [VAL_W-1:0]  move_value;
    logic [1:0]               move_resolution;

    modport source (output valid, func, move_mode, move_value, move_resolution,
                    input ready);
    modport sink (input valid, func, move_mode, move_value, move_resolution,
                  output ready);
endinterface

interface sps_rsp_if;
    import sps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [3:0]           phase_pattern;
    logic                 pins_driven;
    logic                 is_running;
    logic                 stepped;
    logic [POS_W-1:0]     position_now;
    logic [SPEED_W-1:0]   steps_left;
    logic [1:0]           status;

    modport source (output valid, phase_pattern, pins_driven, is_running, stepped,
                    position_now, steps_left, status, input ready);
    modport sink (input valid, phase_pattern, pins_driven, is_running, stepped,
                  position_now, steps_left, status, output ready);
endinterface

interface sps_cfg_if;
    import sps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           index;
    logic [SPEED_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/stepper_phase_sequencer.sv -----
// Top level of the four-phase stepper sequencer with its serial interval divider.
//
// Usage: commands arrive on cmd (tick, power on, power off, move); each accepted
// transaction yields exactly one result transaction on rsp with the coil pattern,
// power and run flags, the step flag, position, remaining steps and a status code.
// cfg takes register writes at any time (ready is always high); index 0 sets
// ticks_per_second, used for the next step interval computed. Indexes 1 and 2
// are accepted, but the initial speed and resolution come back to their reset
// values with every reset, so they load speed 200 and half stepping.
// The result is registered and shows in the cycle after acceptance.
// A command that causes no step leaves cmd free for the next one. A command that steps
// starts the step interval division, ticks_per_second / (speed * resolution),
// done by a restoring divider one quotient bit per cycle, so cmd is not taken
// again until the division for a stepping command ends.
// A stalled receiver holds the result register; cmd is then not ready until the
// pending result transaction completes.
// Reset (rst_n low, asynchronous) powers the motor off, stops it, clears the
// position and drops any pending result. No clearing pass is needed.
`include "assert_macros.svh"

module stepper_phase_sequencer
    import sps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sps_cmd_if.sink    cmd,
    sps_rsp_if.source  rsp,
    sps_cfg_if.sink    cfg
);

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

    state_t               state_reg, state_next;

    logic [TPS_W-1:0]     tps_reg, tps_next;
    logic                 powered_reg, powered_next;
    logic                 running_reg, running_next;
    logic                 dir_up_reg, dir_up_next;
    logic                 pos_mode_reg, pos_mode_next;
    logic [SPEED_W-1:0]   speed_reg, speed_next;
    logic                 half_reg, half_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [SPEED_W-1:0]   remaining_reg, remaining_next;
    logic [TPS_W-1:0]     countdown_reg, countdown_next;

    // Divider: quotient shifts in where the dividend shifts out.
    logic [TPS_W-1:0]     quot_reg, quot_next;
    logic [TPS_W-1:0]     rem_reg, rem_next;
    logic [RATE_W-1:0]    divisor_reg, divisor_next;
    logic [BITCNT_W-1:0]  bitcnt_reg, bitcnt_next;

    // Result register.
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [3:0]           pattern_reg, pattern_next;
    logic                 driven_reg, driven_next;
    logic                 is_running_reg, is_running_next;
    logic                 stepped_reg, stepped_next;
    logic [SPEED_W-1:0]   steps_left_reg, steps_left_next;
    logic [1:0]           status_reg, status_next;

    logic                 cmd_acc;
    logic                 do_worker;
    logic                 val_neg;
    logic [VAL_W-1:0]     val_abs;
    logic [SPEED_W-1:0]   val_mag;
    logic [TPS_W:0]       trial;
    logic                 trial_ge;
    logic [TPS_W:0]       trial_diff;
    logic [TPS_W-1:0]     quot_final;

    assign cmd.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    // Magnitude of the move value, saturated to 31 bits.
    assign val_neg = cmd.move_value[VAL_W-1];
    assign val_abs = val_neg ? (~cmd.move_value + 1'b1) : cmd.move_value;
    assign val_mag = val_abs[VAL_W-1] ? MAG_MAX : val_abs[SPEED_W-1:0];

    // One restoring division step.
    assign trial      = {rem_reg, quot_reg[TPS_W-1]};
    assign trial_ge   = {{(RATE_W-TPS_W-1){1'b0}}, trial} >= divisor_reg;
    assign trial_diff = trial - divisor_reg[TPS_W:0];
    assign quot_final = {quot_reg[TPS_W-2:0], trial_ge};

    always_comb
    begin
        state_next      = state_reg;
        tps_next        = tps_reg;
        powered_next    = powered_reg;
        running_next    = running_reg;
        dir_up_next     = dir_up_reg;
        pos_mode_next   = pos_mode_reg;
        speed_next      = speed_reg;
        half_next       = half_reg;
        position_next   = position_reg;
        remaining_next  = remaining_reg;
        countdown_next  = countdown_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        bitcnt_next     = bitcnt_reg;
        rsp_valid_next  = rsp_valid_reg;
        pattern_next    = pattern_reg;
        driven_next     = driven_reg;
        is_running_next = is_running_reg;
        stepped_next    = stepped_reg;
        steps_left_next = steps_left_reg;
        status_next     = status_reg;
        do_worker       = 1'b0;

        // Configuration write.
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_TICKS_PER_SECOND:   tps_next = cfg.data[TPS_W-1:0];
                REG_INITIAL_SPEED:      ;
                REG_INITIAL_RESOLUTION: ;
                default:                ;
            endcase
        end

        // Drop the result once the receiver takes it.
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        // Advance the interval divider one bit.
        if (state_reg == ST_DIV)
        begin
            quot_next = quot_final;
            rem_next  = trial_ge ? trial_diff[TPS_W-1:0] : trial[TPS_W-1:0];
            if (bitcnt_reg == '0)
            begin
                countdown_next = (quot_final == '0) ? TPS_W'(1) : quot_final;
                state_next     = ST_IDLE;
            end
            else
            begin
                bitcnt_next = bitcnt_reg - 1'b1;
            end
        end

        if (cmd_acc)
        begin
            status_next = STATUS_OK;

            // Decode the command.
            case (func_t'(cmd.func))
                FUNC_TICK:
                begin
                    if (running_reg)
                    begin
                        if (countdown_reg <= TPS_W'(1))
                            do_worker = 1'b1;
                        else
                            countdown_next = countdown_reg - 1'b1;
                    end
                end
                FUNC_POWER_ON:
                begin
                    powered_next = 1'b1;
                end
                FUNC_POWER_OFF:
                begin
                    running_next = 1'b0;
                    powered_next = 1'b0;
                end
                FUNC_MOVE:
                begin
                    if (!powered_reg)
                        status_next = STATUS_POWERED_OFF;
                    else if (cmd.move_mode != MODE_POSITION && cmd.move_mode != MODE_VELOCITY)
                        status_next = STATUS_BAD_MODE;
                    else
                    begin
                        if (cmd.move_mode == MODE_POSITION)
                        begin
                            pos_mode_next  = 1'b1;
                            remaining_next = val_mag;
                        end
                        else
                        begin
                            pos_mode_next = 1'b0;
                            speed_next    = val_mag;
                        end
                        half_next    = cmd.move_resolution[1];
                        dir_up_next  = !val_neg && (cmd.move_value != '0);
                        running_next = 1'b1;
                        do_worker    = 1'b1;
                    end
                end
                default: ;
            endcase

            // Take one step and start the interval division, or stop if no step can be taken.
            stepped_next = 1'b0;
            if (do_worker)
            begin
                if (!(powered_next && running_next && speed_next != '0))
                begin
                    running_next = 1'b0;
                end
                else
                begin
                    stepped_next  = 1'b1;
                    position_next = dir_up_next ? position_reg + 1'b1 : position_reg - 1'b1;
                    if (pos_mode_next && remaining_next != '0)
                        remaining_next = remaining_next - 1'b1;
                    if (pos_mode_next && remaining_next == '0)
                        running_next = 1'b0;
                    quot_next    = tps_reg;
                    rem_next     = '0;
                    divisor_next = half_next ? {speed_next, 1'b0} : {1'b0, speed_next};
                    bitcnt_next  = BITCNT_W'(TPS_W - 1);
                    state_next   = ST_DIV;
                end
            end

            // Load the result register.
            rsp_valid_next  = 1'b1;
            pattern_next    = powered_next ? phase_lookup(half_next, position_next[2:0])
                                           : 4'h0;
            driven_next     = powered_next;
            is_running_next = running_next;
            steps_left_next = remaining_next;
        end
    end

    // Hold state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tps_reg        <= TPS_RESET;
            powered_reg    <= 1'b0;
            running_reg    <= 1'b0;
            dir_up_reg     <= 1'b1;
            pos_mode_reg   <= 1'b1;
            speed_reg      <= SPEED_RESET;
            half_reg       <= HALF_RESET;
            position_reg   <= '0;
            remaining_reg  <= '0;
            countdown_reg  <= '0;
            quot_reg       <= '0;
            rem_reg        <= '0;
            divisor_reg    <= '0;
            bitcnt_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
            pattern_reg    <= '0;
            driven_reg     <= 1'b0;
            is_running_reg <= 1'b0;
            stepped_reg    <= 1'b0;
            steps_left_reg <= '0;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            tps_reg        <= tps_next;
            powered_reg    <= powered_next;
            running_reg    <= running_next;
            dir_up_reg     <= dir_up_next;
            pos_mode_reg   <= pos_mode_next;
            speed_reg      <= speed_next;
            half_reg       <= half_next;
            position_reg   <= position_next;
            remaining_reg  <= remaining_next;
            countdown_reg  <= countdown_next;
            quot_reg       <= quot_next;
            rem_reg        <= rem_next;
            divisor_reg    <= divisor_next;
            bitcnt_reg     <= bitcnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            pattern_reg    <= pattern_next;
            driven_reg     <= driven_next;
            is_running_reg <= is_running_next;
            stepped_reg    <= stepped_next;
            steps_left_reg <= steps_left_next;
            status_reg     <= status_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.phase_pattern = pattern_reg;
    assign rsp.pins_driven   = driven_reg;
    assign rsp.is_running    = is_running_reg;
    assign rsp.stepped       = stepped_reg;
    assign rsp.position_now  = position_reg;
    assign rsp.steps_left    = steps_left_reg;
    assign rsp.status        = status_reg;

    `SPS_ASSERT(a_step_needs_power, rsp.valid && rsp.stepped |-> rsp.pins_driven, "step while unpowered")
    `SPS_ASSERT(a_run_needs_power, rsp.valid && rsp.is_running |-> rsp.pins_driven, "running while unpowered")
    `SPS_ASSERT(a_reject_no_step, rsp.valid && rsp.status != STATUS_OK |-> !rsp.stepped, "rejected move stepped")
    `SPS_ASSERT(a_interval_nonzero, state_reg == ST_DIV && bitcnt_reg == '0 |=> countdown_reg != '0, "zero step interval")
    `SPS_ASSERT(a_step_starts_div, cmd_acc && stepped_next |=> state_reg == ST_DIV, "step without interval division")

endmodule
